// ===== rtl/jsu_pkg.sv =====
// Shared types, character codes and helper functions for the JSON string unescaper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LC_B  = 8'h62;
   localparam logic [7:0] CH_LC_F  = 8'h66;
   localparam logic [7:0] CH_LC_N  = 8'h6E;
   localparam logic [7:0] CH_LC_R  = 8'h72;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_LC_U  = 8'h75;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_TAB = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;

   localparam int CP_W = 21;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_NO_QUOTE    = 4'd1,
      ST_UNTERM      = 4'd2,
      ST_UNTERM_ESC  = 4'd3,
      ST_BAD_ESC     = 4'd4,
      ST_BAD_HEX     = 4'd5,
      ST_BAD_PAIR    = 4'd6,
      ST_BAD_LOW     = 4'd7,
      ST_LONE_LOW    = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      PH_WAIT, PH_STR, PH_ESC, PH_HEX1, PH_BSL, PH_U, PH_HEX2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_CP, CMD_DONE, CMD_ERR, CMD_RAW
   } cmd_kind_type;

   // One queued job for the back end: a raw byte to pass through, a code point to encode,
   // a done mark or an error.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [CP_W-1:0]   cp;
      status_type        status;
   } cmd_type;

   // Bit 4 is set when the byte is a hex digit; bits 3:0 carry its value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   // Number of UTF-8 bytes minus one for a code point.
   function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
      logic [1:0] r;
      if (cp <= 21'h7F) r = 2'd0;
      else if (cp <= 21'h7FF) r = 2'd1;
      else if (cp <= 21'hFFFF) r = 2'd2;
      else r = 2'd3;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// A byte that completes a result passes through the job queue and the output register before
// its first beat shows. Throughput: one byte accepted per cycle while the job queue has room;
// the back end sends one result beat per cycle while the consumer is ready, so a \u escape of
// two, three or four UTF-8 bytes holds the back end for one beat per byte; the queue absorbs the burst.
// Reset is synchronous and active high: it clears the phase, the escape state, the queue
// pointers and the output valid; there is no clearing pass and no memory to sweep.
`default_nettype none
module json_string_unescape_utf8
   import jsu_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_input_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_string_done,
   output logic [3:0]      rsp_status,
   output logic            rsp_last
);

   // The front end decides, for each accepted beat, whether it yields a job: a raw byte,
   // a code point, a done mark or an error. Bytes that only move the phase along (the opening quote,
   // a backslash, the u of an escape, hex digits before the fourth, every digit of a high surrogate) produce nothing.
   logic    push, pop, queue_full, head_valid;
   cmd_type push_cmd, head_cmd;

   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_input_end (req_input_end),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // The queue lets the front end keep taking bytes while the back end is stalled by the
   // consumer or busy with a multi-byte sequence.
   jsu_fifo #(
      .DEPTH (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The back end turns each job into one or more beats held in an output register, so a
   // waiting result does not block the input side until the job queue is full.
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Front end: accepts raw bytes, tracks the string and escape phase, and queues jobs.
// Depends on jsu_pkg.
`default_nettype none
module jsu_front
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_input_end,
   input  wire logic       queue_full,
   output logic            push,
   output cmd_type         push_cmd
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_accum_ff, code_accum_in;
   logic [9:0]  high_part_ff, high_part_in;

   logic        accept;
   logic        end_in;
   logic [4:0]  hex;
   logic        hex_ok;
   logic [15:0] accum_next;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign end_in     = req_input_end || (req_ch == CH_NUL);
   assign hex        = hex_value(req_ch);
   assign hex_ok     = !end_in && hex[4];
   assign accum_next = {code_accum_ff[11:0], hex[3:0]};

   always_comb begin
      phase_in      = phase_ff;
      hex_count_in  = hex_count_ff;
      code_accum_in = code_accum_ff;
      high_part_in  = high_part_ff;
      push          = 1'b0;
      push_cmd      = '{kind: CMD_ERR, cp: '0, status: ST_NO_QUOTE};

      case (phase_ff)
         PH_WAIT: begin
            if (!end_in && req_ch == CH_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               push = 1'b1;
            end
         end
         PH_STR: begin
            if (end_in) begin
               push            = 1'b1;
               push_cmd.status = ST_UNTERM;
            end else if (req_ch == CH_QUOTE) begin
               push            = 1'b1;
               push_cmd.kind   = CMD_DONE;
               push_cmd.status = ST_OK;
               phase_in        = PH_WAIT;
            end else if (req_ch == CH_BSL) begin
               phase_in = PH_ESC;
            end else begin
               // Any other byte goes out unchanged as a single beat, top bit set or not.
               push     = 1'b1;
               push_cmd = '{kind: CMD_RAW, cp: CP_W'(req_ch), status: ST_OK};
            end
         end
         PH_ESC: begin
            push     = 1'b1;
            push_cmd = '{kind: CMD_CP, cp: '0, status: ST_OK};
            phase_in = PH_STR;
            if (end_in) begin
               push_cmd = '{kind: CMD_ERR, cp: '0, status: ST_UNTERM_ESC};
            end else begin
               case (req_ch)
                  CH_QUOTE, CH_BSL, CH_SLASH: push_cmd.cp = CP_W'(req_ch);
                  CH_LC_N: push_cmd.cp = CP_W'(CTRL_LF);
                  CH_LC_T: push_cmd.cp = CP_W'(CTRL_TAB);
                  CH_LC_R: push_cmd.cp = CP_W'(CTRL_CR);
                  CH_LC_B: push_cmd.cp = CP_W'(CTRL_BS);
                  CH_LC_F: push_cmd.cp = CP_W'(CTRL_FF);
                  CH_LC_U: begin
                     push          = 1'b0;
                     phase_in      = PH_HEX1;
                     hex_count_in  = 2'd0;
                     code_accum_in = 16'd0;
                  end
                  default: push_cmd = '{kind: CMD_ERR, cp: '0, status: ST_BAD_ESC};
               endcase
            end
         end
         PH_HEX1, PH_HEX2: begin
            if (!hex_ok) begin
               push            = 1'b1;
               push_cmd.status = ST_BAD_HEX;
            end else begin
               code_accum_in = accum_next;
               hex_count_in  = hex_count_ff + 2'd1;
               if (hex_count_ff == 2'd3) begin
                  push = 1'b1;
                  if (phase_ff == PH_HEX1) begin
                     if (accum_next >= 16'hD800 && accum_next <= 16'hDBFF) begin
                        push         = 1'b0;
                        high_part_in = accum_next[9:0];
                        phase_in     = PH_BSL;
                     end else if (accum_next >= 16'hDC00 && accum_next <= 16'hDFFF) begin
                        push_cmd.status = ST_LONE_LOW;
                     end else begin
                        push_cmd = '{kind: CMD_CP, cp: CP_W'(accum_next), status: ST_OK};
                        phase_in = PH_STR;
                     end
                  end else begin
                     if (accum_next < 16'hDC00 || accum_next > 16'hDFFF) begin
                        push_cmd.status = ST_BAD_LOW;
                     end else begin
                        push_cmd = '{kind: CMD_CP,
                                     cp: 21'h10000 + CP_W'({high_part_ff, accum_next[9:0]}),
                                     status: ST_OK};
                        phase_in = PH_STR;
                     end
                  end
               end
            end
         end
         PH_BSL: begin
            if (!end_in && req_ch == CH_BSL) begin
               phase_in = PH_U;
            end else begin
               push            = 1'b1;
               push_cmd.status = ST_BAD_PAIR;
            end
         end
         PH_U: begin
            if (!end_in && req_ch == CH_LC_U) begin
               phase_in      = PH_HEX2;
               hex_count_in  = 2'd0;
               code_accum_in = 16'd0;
            end else begin
               push            = 1'b1;
               push_cmd.status = ST_BAD_PAIR;
            end
         end
         default: begin
            push = 1'b1;
         end
      endcase

      // Every error sends the block back to waiting with the escape state cleared.
      if (push && push_cmd.kind == CMD_ERR) begin
         phase_in      = PH_WAIT;
         hex_count_in  = 2'd0;
         code_accum_in = 16'd0;
         high_part_in  = 10'd0;
      end
      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         hex_count_ff  <= 2'd0;
         code_accum_ff <= 16'd0;
         high_part_ff  <= 10'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         hex_count_ff  <= hex_count_in;
         code_accum_ff <= code_accum_in;
         high_part_ff  <= high_part_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsu_fifo.sv =====
// Short job queue between the front end and the UTF-8 back end.
// Depends on jsu_pkg for the job type.
`default_nettype none
module jsu_fifo
   import jsu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Back end: expands queued jobs into result beats, one UTF-8 byte per beat for a code point.
// Depends on jsu_pkg.
`default_nettype none
module jsu_back
   import jsu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic [3:0] rsp_status,
   output logic       rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_bvalid_ff, rsp_done_ff, rsp_last_ff;
   status_type rsp_status_ff;

   logic       load;
   logic [1:0] len;
   logic [7:0] beat_byte;
   logic       beat_last;
   logic [CP_W-1:0] cp;

   assign cp        = head_cmd.cp;
   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign len       = (head_cmd.kind == CMD_CP) ? utf8_len(cp) : 2'd0;
   assign beat_last = (idx_ff == len);
   assign pop       = load && beat_last;
   assign idx_in    = beat_last ? 2'd0 : idx_ff + 2'd1;

   always_comb begin
      beat_byte = 8'h00;
      case (len)
         2'd0: beat_byte = {1'b0, cp[6:0]};
         2'd1: beat_byte = (idx_ff == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         2'd2: begin
            case (idx_ff)
               2'd0:    beat_byte = {4'b1110, cp[15:12]};
               2'd1:    beat_byte = {2'b10, cp[11:6]};
               default: beat_byte = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx_ff)
               2'd0:    beat_byte = {5'b11110, cp[20:18]};
               2'd1:    beat_byte = {2'b10, cp[17:12]};
               2'd2:    beat_byte = {2'b10, cp[11:6]};
               default: beat_byte = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      if (head_cmd.kind == CMD_RAW) begin
         beat_byte = cp[7:0];
      end else if (head_cmd.kind != CMD_CP) begin
         beat_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= idx_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff   <= beat_byte;
         rsp_bvalid_ff <= (head_cmd.kind == CMD_CP) || (head_cmd.kind == CMD_RAW);
         rsp_done_ff   <= (head_cmd.kind == CMD_DONE);
         rsp_status_ff <= (head_cmd.kind == CMD_ERR) ? head_cmd.status : ST_OK;
         rsp_last_ff   <= beat_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bvalid_ff;
   assign rsp_string_done = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   // A code point part-way through encoding keeps its job at the head of the queue.
   a_idx_holds_job: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> head_valid)
      else $error("byte index set with no job at queue head");

   a_mid_beat_advances: assert property (@(posedge clock) disable iff (reset)
      load && !beat_last |=> idx_ff != 2'd0)
      else $error("multi-byte code point lost its byte index");

   a_byte_beat_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bvalid_ff |-> rsp_status_ff == ST_OK && !rsp_done_ff)
      else $error("data beat carries status or done");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_last_ff && !rsp_bvalid_ff)
      else $error("error beat not marked last");

endmodule
`default_nettype wire

// ===== tb/json_string_unescape_utf8_tb.sv =====
// Self-checking bench for the JSON string unescaper: a byte-level decoder model predicts every
// UTF-8, done and error beat, and an in-order monitor compares them field by field.
// Depends on jsu_pkg for the status codes, phase names and character codes, and on the RTL top.
module json_string_unescape_utf8_tb;
   import jsu_pkg::*;

   localparam int RandomBytes     = 410;
   localparam int LongStallAt     = 40;
   localparam int LongStallCycles = 120;

   // One input beat as the sender will offer it, with the idle gap it waits beforehand and a
   // flag that holds it back until every predicted result has been taken.
   typedef struct {
      logic [7:0]  ch;
      logic        input_end;
      int unsigned gap;
      bit          drain;
   } json_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic [3:0] status;
      logic       last;
   } utf8_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_input_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_done;
   logic [3:0] rsp_status;
   logic       rsp_last;

   json_byte_type  bytes_to_send[$];
   utf8_beat_type  decoded_due[$];
   int unsigned items_total;
   int unsigned items_accepted;
   int unsigned beats_seen;
   int unsigned failures;
   int unsigned gap_left;
   bit          gap_armed;
   int unsigned hold_left;
   int unsigned steady_left;
   bit          drain_next;

   // Decoder state of the prediction, kept at the widths of the block.
   phase_type   str_phase;
   logic [1:0]  hex_count;
   logic [15:0] code_accum;
   logic [9:0]  high_part;
   int unsigned beats_this_step;

   logic [7:0] escape_letters [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_LC_B,
                                      CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

   json_string_unescape_utf8 u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_input_end   (req_input_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------------------------

   function automatic void add_beat(input logic [7:0] b, input logic bv, input logic done,
                                    input logic [3:0] st);
      utf8_beat_type beat;
      beat.out_byte    = b;
      beat.byte_valid  = bv;
      beat.string_done = done;
      beat.status      = st;
      beat.last        = 1'b0;
      decoded_due.insert(decoded_due.size(), beat);
      beats_this_step++;
   endfunction

   // Every error gives a single status beat and drops the decoder back to hunting for a quote.
   function automatic void abort_string(input logic [3:0] st);
      add_beat(8'h00, 1'b0, 1'b0, st);
      str_phase  = PH_WAIT;
      hex_count  = 2'd0;
      code_accum = 16'h0000;
      high_part  = 10'h000;
   endfunction

   // Shifts one hex digit into the code unit; true once the fourth digit has arrived.
   function automatic bit take_hex_digit(input logic [7:0] c, input logic at_end);
      logic [3:0] nibble;
      if (!at_end && c >= 8'h30 && c <= 8'h39) begin
         nibble = c[3:0];
      end else if (!at_end && ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))) begin
         // The low nibble of 'a' and 'A' is 1, so adding nine gives ten.
         nibble = c[3:0] + 4'd9;
      end else begin
         abort_string(ST_BAD_HEX);
         return 1'b0;
      end
      code_accum = {code_accum[11:0], nibble};
      hex_count  = hex_count + 2'd1;
      return hex_count == 2'd0;
   endfunction

   function automatic void encode_utf8(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         add_beat(cp[7:0], 1'b1, 1'b0, ST_OK);
      end else if (cp <= 21'h7FF) begin
         add_beat({3'b110, cp[10:6]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
      end else if (cp <= 21'hFFFF) begin
         add_beat({4'b1110, cp[15:12]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
      end else begin
         add_beat({5'b11110, cp[20:18]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[17:12]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
         add_beat({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
      end
   endfunction

   // Advances the model by one accepted input beat and queues the result beats it causes.
   function automatic void decode_byte(input logic [7:0] c, input logic eoi);
      logic          at_end;
      utf8_beat_type tail;
      at_end = eoi || (c == CH_NUL);
      beats_this_step = 0;
      case (str_phase)
         PH_WAIT: begin
            if (!at_end && c == CH_QUOTE) str_phase = PH_STR;
            else abort_string(ST_NO_QUOTE);
         end
         PH_STR: begin
            if (at_end) begin
               abort_string(ST_UNTERM);
            end else if (c == CH_QUOTE) begin
               add_beat(8'h00, 1'b0, 1'b1, ST_OK);
               str_phase = PH_WAIT;
            end else if (c == CH_BSL) begin
               str_phase = PH_ESC;
            end else begin
               add_beat(c, 1'b1, 1'b0, ST_OK);
            end
         end
         PH_ESC: begin
            if (at_end) begin
               abort_string(ST_UNTERM_ESC);
            end else begin
               str_phase = PH_STR;
               case (c)
                  CH_QUOTE, CH_BSL, CH_SLASH: add_beat(c, 1'b1, 1'b0, ST_OK);
                  CH_LC_N: add_beat(CTRL_LF, 1'b1, 1'b0, ST_OK);
                  CH_LC_T: add_beat(CTRL_TAB, 1'b1, 1'b0, ST_OK);
                  CH_LC_R: add_beat(CTRL_CR, 1'b1, 1'b0, ST_OK);
                  CH_LC_B: add_beat(CTRL_BS, 1'b1, 1'b0, ST_OK);
                  CH_LC_F: add_beat(CTRL_FF, 1'b1, 1'b0, ST_OK);
                  CH_LC_U: begin
                     str_phase  = PH_HEX1;
                     hex_count  = 2'd0;
                     code_accum = 16'h0000;
                  end
                  default: abort_string(ST_BAD_ESC);
               endcase
            end
         end
         PH_HEX1: begin
            if (take_hex_digit(c, at_end)) begin
               if (code_accum >= 16'hD800 && code_accum <= 16'hDBFF) begin
                  high_part = code_accum[9:0];
                  str_phase = PH_BSL;
               end else if (code_accum >= 16'hDC00 && code_accum <= 16'hDFFF) begin
                  abort_string(ST_LONE_LOW);
               end else begin
                  encode_utf8({5'd0, code_accum});
                  str_phase = PH_STR;
               end
            end
         end
         PH_BSL: begin
            if (!at_end && c == CH_BSL) str_phase = PH_U;
            else abort_string(ST_BAD_PAIR);
         end
         PH_U: begin
            if (!at_end && c == CH_LC_U) begin
               str_phase  = PH_HEX2;
               hex_count  = 2'd0;
               code_accum = 16'h0000;
            end else begin
               abort_string(ST_BAD_PAIR);
            end
         end
         PH_HEX2: begin
            if (take_hex_digit(c, at_end)) begin
               if (code_accum < 16'hDC00 || code_accum > 16'hDFFF) begin
                  abort_string(ST_BAD_LOW);
               end else begin
                  // Both halves carry ten bits each; the pair lands above the basic plane.
                  encode_utf8(21'h10000 + {1'b0, high_part, code_accum[9:0]});
                  str_phase = PH_STR;
               end
            end
         end
         default: abort_string(ST_NO_QUOTE);
      endcase
      // Only the final beat of this input carries the last mark.
      if (beats_this_step > 0) begin
         tail = decoded_due[decoded_due.size() - 1];
         tail.last = 1'b1;
         decoded_due[decoded_due.size() - 1] = tail;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------------------

   // The sender's idle gap is drawn here, per byte. Now and then a run of bytes gets no gap
   // at all so that the input sees back-to-back beats for a while.
   task automatic queue_byte(input logic [7:0] c, input logic eoi);
      json_byte_type item;
      item.ch        = c;
      item.input_end = eoi;
      item.drain     = drain_next;
      drain_next     = 1'b0;
      if (steady_left > 0) begin
         steady_left--;
         item.gap = 0;
      end else begin
         if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(16, 40);
         item.gap = $urandom_range(0, 3);
      end
      bytes_to_send.insert(bytes_to_send.size(), item);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
   endtask

   // End of data comes either as a zero byte or as the end mark with a random byte beside it.
   task automatic queue_stop();
      if ($urandom_range(0, 1) == 0) queue_byte(CH_NUL, 1'b0);
      else queue_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      // Letters come in either case at random.
      return (($urandom_range(0, 1) == 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   task automatic queue_u_escape(input logic [15:0] v);
      queue_byte(CH_BSL, 1'b0);
      queue_byte(CH_LC_U, 1'b0);
      queue_byte(hex_char(v[15:12]), 1'b0);
      queue_byte(hex_char(v[11:8]), 1'b0);
      queue_byte(hex_char(v[7:4]), 1'b0);
      queue_byte(hex_char(v[3:0]), 1'b0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Input driver: offers queued bytes, predicts each one as its beat is accepted.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      json_byte_type next_item;
      bit            launch;
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_ch, req_input_end);
            items_accepted++;
         end
         // The payload may change only once the current beat has gone.
         if (!req_valid || req_ready) begin
            launch = 1'b0;
            if (bytes_to_send.size() > 0) begin
               if (!gap_armed) begin
                  gap_left  = bytes_to_send[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left > 0) gap_left--;
               else if (!bytes_to_send[0].drain || decoded_due.size() == 0) launch = 1'b1;
            end
            if (launch) begin
               next_item = bytes_to_send.pop_front();
               req_ch        <= next_item.ch;
               req_input_end <= next_item.input_end;
               gap_armed = 1'b0;
            end
            req_valid <= launch;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor and receiver back-pressure
   // ---------------------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         failures++;
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      utf8_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_due.size() == 0) begin
               failures++;
               $error("result beat with none predicted: out_byte %0h status %0d",
                      rsp_out_byte, rsp_status);
            end else begin
               want = decoded_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
               check_field("string_done", 8'(want.string_done), 8'(rsp_string_done));
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
            beats_seen++;
            // One long hold-off lets the job queue fill and push back on the input; every
            // fourth block of fifty beats is taken without any stall.
            if (beats_seen == LongStallAt) hold_left = LongStallCycles;
            else if ((beats_seen / 50) % 4 == 2) hold_left = 0;
            else hold_left = $urandom_range(0, 3);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [7:0]  b;
      logic [15:0] hi;
      int unsigned segments;
      bit          broken;

      str_phase   = PH_WAIT;
      hex_count   = 2'd0;
      code_accum  = 16'h0000;
      high_part   = 10'h000;
      failures    = 0;
      steady_left = 0;
      drain_next  = 1'b0;

      // Directed opening: a stray byte and an end mark while hunting for the quote, a zero
      // byte ending a string, the top byte and a control byte passing through raw, a simple
      // escape, the highest surrogate pair (four UTF-8 bytes), a clean close and a bad escape.
      queue_text("A");
      queue_byte(CH_QUOTE, 1'b1);
      queue_text("\"");
      queue_byte(CH_NUL, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_text("\\n\\uDbFf\\udFFF\"");
      queue_text("\"\\q");

      // Random strings: mostly well-formed text with random content, some stray bytes
      // between strings, and now and then a string broken by one of the error cases.
      drain_next = 1'b1;
      while (bytes_to_send.size() < RandomBytes) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end
         queue_byte(CH_QUOTE, 1'b0);
         segments = $urandom_range(0, 8);
         broken = 1'b0;
         for (int i = 0; i < segments && !broken; i++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSL);
                  queue_byte(b, 1'b0);
               end
               4, 5: begin
                  queue_byte(CH_BSL, 1'b0);
                  queue_byte(escape_letters[$urandom_range(0, 7)], 1'b0);
               end
               6, 7: begin
                  case ($urandom_range(0, 5))
                     0: queue_u_escape(16'($urandom_range(0, 16'h7F)));
                     1: queue_u_escape(16'($urandom_range(16'h80, 16'h7FF)));
                     2: queue_u_escape(16'($urandom_range(16'h800, 16'hD7FF)));
                     3: queue_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
                     4: queue_u_escape(($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF);
                     default: queue_u_escape(16'($urandom_range(0, 16'hFFFF)));
                  endcase
               end
               8: begin
                  queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                  queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
               end
               default: begin
                  broken = 1'b1;
                  hi = 16'($urandom_range(16'hD800, 16'hDBFF));
                  case ($urandom_range(0, 6))
                     0: begin
                        // Data runs out straight after a backslash.
                        queue_byte(CH_BSL, 1'b0);
                        queue_stop();
                     end
                     1: begin
                        queue_byte(CH_BSL, 1'b0);
                        queue_byte(8'($urandom_range(0, 255)), 1'b0);
                     end
                     2: begin
                        // A \u escape with up to three hex digits, then a random byte or the end of data.
                        queue_byte(CH_BSL, 1'b0);
                        queue_byte(CH_LC_U, 1'b0);
                        repeat ($urandom_range(0, 3))
                           queue_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        if ($urandom_range(0, 1) == 0) queue_stop();
                        else queue_byte(8'($urandom_range(0, 255)), 1'b0);
                     end
                     3: begin
                        // High surrogate with no second escape behind it.
                        queue_u_escape(hi);
                        if ($urandom_range(0, 1) == 0) queue_stop();
                        else queue_byte(8'($urandom_range(0, 255)), 1'b0);
                     end
                     4: begin
                        queue_u_escape(hi);
                        queue_byte(CH_BSL, 1'b0);
                        queue_byte(8'($urandom_range(0, 255)), 1'b0);
                     end
                     5: begin
                        // Second half of the pair outside the low surrogate range.
                        queue_u_escape(hi);
                        if ($urandom_range(0, 1) == 0)
                           queue_u_escape(16'($urandom_range(0, 16'hDBFF)));
                        else
                           queue_u_escape(16'($urandom_range(16'hE000, 16'hFFFF)));
                     end
                     default: begin
                        // A low surrogate with nothing in front of it.
                        queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                     end
                  endcase
               end
            endcase
         end
         if (!broken) begin
            // Most strings close properly; a few simply run out of data.
            if ($urandom_range(0, 11) == 0) queue_stop();
            else queue_byte(CH_QUOTE, 1'b0);
         end
         if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
      end
      items_total = bytes_to_send.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sampling away from the rising edge keeps these checks clear of the driver's updates.
      while (items_accepted < items_total) @(negedge clock);
      while (decoded_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (failures == 0 && decoded_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // The slowest correct run stays well under a tenth of this.
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
